// ===== sv/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared constants and controller/datapath interface types for the
// byte-serial sponge stream cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_ABSORB  = 2'd0;
    localparam logic [1:0] CMD_PROCESS = 2'd1;
    localparam logic [1:0] CMD_SQUEEZE = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // cipher constants
    localparam logic [7:0] RESET_FILL = 8'd3;
    localparam logic [7:0] HALF_POINT = 8'd128;
    localparam logic [7:0] STEP_INC   = 8'd2;
    localparam int         REMIX_ROUNDS = 512;
    localparam int         CNT_W        = $clog2(REMIX_ROUNDS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(REMIX_ROUNDS - 1);

    // sequencer step codes, shared by controller and datapath
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] ST_IDLE  = 5'd0;
    localparam logic [STEP_W-1:0] ST_JADD  = 5'd1;
    localparam logic [STEP_W-1:0] ST_NCHK  = 5'd2;
    localparam logic [STEP_W-1:0] ST_NR0   = 5'd3;
    localparam logic [STEP_W-1:0] ST_NR1   = 5'd4;
    localparam logic [STEP_W-1:0] ST_NW0   = 5'd5;
    localparam logic [STEP_W-1:0] ST_NW1   = 5'd6;
    localparam logic [STEP_W-1:0] ST_UA    = 5'd7;
    localparam logic [STEP_W-1:0] ST_UB    = 5'd8;
    localparam logic [STEP_W-1:0] ST_UC    = 5'd9;
    localparam logic [STEP_W-1:0] ST_UD    = 5'd10;
    localparam logic [STEP_W-1:0] ST_UE    = 5'd11;
    localparam logic [STEP_W-1:0] ST_RDONE = 5'd12;
    localparam logic [STEP_W-1:0] ST_KA    = 5'd13;
    localparam logic [STEP_W-1:0] ST_KB    = 5'd14;
    localparam logic [STEP_W-1:0] ST_KC    = 5'd15;
    localparam logic [STEP_W-1:0] ST_KD    = 5'd16;
    localparam logic [STEP_W-1:0] ST_EMIT  = 5'd17;

    // controller to datapath
    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              take;      // input transfer this cycle
        logic              nib_hi;    // absorbing the high nibble
        logic              proc;      // current item is a process command
        logic              load_out;  // move the result into the output register
    } ssc_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic ptr_half;   // absorb pointer sits at the half point
        logic out_free;   // output register can take a result this cycle
    } ssc_sts_t;

endpackage

`default_nettype wire

// ===== sv/ssc_datapath.sv =====
// ----------------------------------------------------------------------------
// ssc_datapath
// Permutation memory, cipher registers and output register. Carries out at
// most one memory access per step as commanded by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_datapath
    import ssc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ssc_ctl_t   ctl,
    output ssc_sts_t        sts,
    input  wire logic [7:0] in_byte,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic [7:0]      out_byte
);

    // permutation memory with per-entry valid bits
    logic [7:0]   mem [0:255];
    logic [255:0] valid_reg;
    logic [7:0]   rdata_q;
    logic         rvalid_q;
    logic [7:0]   raddr_q;
    logic [7:0]   raddr;
    logic         we;
    logic [7:0]   waddr;
    logic [7:0]   wdata;
    logic [7:0]   rd;

    // cipher registers
    logic [7:0] i_reg, i_next;
    logic [7:0] j_reg, j_next;
    logic [7:0] k_reg, k_next;
    logic [7:0] w_reg, w_next;
    logic [7:0] ptr_reg, ptr_next;
    logic [7:0] last_reg, last_next;
    logic [7:0] ta_reg, ta_next;
    logic [7:0] b_reg, b_next;
    logic [7:0] d_reg, d_next;
    logic [7:0] r_reg, r_next;
    logic       decrypt_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;

    logic [3:0] nib;
    logic [7:0] hi_addr;
    logic [7:0] absorb_src;

    // unwritten entries read as their reset value
    assign rd = rvalid_q ? rdata_q : (raddr_q + RESET_FILL);

    assign nib        = ctl.nib_hi ? b_reg[7:4] : b_reg[3:0];
    assign hi_addr    = HALF_POINT + {4'b0000, nib};
    assign absorb_src = (ctl.proc && decrypt_reg) ? r_reg : d_reg;

    // step decode
    always_comb begin
        i_next    = i_reg;
        j_next    = j_reg;
        k_next    = k_reg;
        w_next    = w_reg;
        ptr_next  = ptr_reg;
        last_next = last_reg;
        ta_next   = ta_reg;
        b_next    = b_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        raddr     = 8'd0;
        we        = 1'b0;
        waddr     = 8'd0;
        wdata     = 8'd0;
        case (ctl.step)
            ST_IDLE: begin
                if (ctl.take) begin
                    d_next = in_byte;
                end
            end
            ST_KA: raddr = last_reg + k_reg;
            ST_KB: raddr = i_reg + rd;
            ST_KC: raddr = j_reg + rd;
            ST_KD: begin
                last_next = rd;
                r_next    = ctl.proc ? (rd ^ d_reg) : rd;
            end
            ST_JADD: begin
                b_next = absorb_src;
                j_next = j_reg + absorb_src;
            end
            ST_RDONE: begin
                w_next   = w_reg + STEP_INC;
                ptr_next = 8'd0;
            end
            ST_NR0: raddr = ptr_reg;
            ST_NR1: begin
                ta_next = rd;
                raddr   = hi_addr;
            end
            ST_NW0: begin
                we    = 1'b1;
                waddr = ptr_reg;
                wdata = rd;
            end
            ST_NW1: begin
                we       = 1'b1;
                waddr    = hi_addr;
                wdata    = ta_reg;
                ptr_next = ptr_reg + 8'd1;
            end
            ST_UA: begin
                i_next = i_reg + w_reg;
                raddr  = i_reg + w_reg;
            end
            ST_UB: begin
                ta_next = rd;
                raddr   = j_reg + rd;
            end
            ST_UC: begin
                j_next = k_reg + rd;
                raddr  = k_reg + rd;
            end
            ST_UD: begin
                k_next = i_reg + k_reg + rd;
                we     = 1'b1;
                waddr  = i_reg;
                wdata  = rd;
            end
            ST_UE: begin
                we    = 1'b1;
                waddr = j_reg;
                wdata = ta_reg;
            end
            default: begin
            end
        endcase
    end

    // memory array, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_q <= mem[raddr];
        raddr_q <= raddr;
    end

    // valid bits and read-side valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rvalid_q  <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_q <= valid_reg[raddr];
        end
    end

    // cipher state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg    <= RESET_FILL;
            j_reg    <= RESET_FILL;
            k_reg    <= RESET_FILL;
            w_reg    <= RESET_FILL;
            ptr_reg  <= RESET_FILL;
            last_reg <= RESET_FILL;
        end else begin
            i_reg    <= i_next;
            j_reg    <= j_next;
            k_reg    <= k_next;
            w_reg    <= w_next;
            ptr_reg  <= ptr_next;
            last_reg <= last_next;
        end
    end

    // scratch registers
    always_ff @(posedge aclk) begin
        ta_reg <= ta_next;
        b_reg  <= b_next;
        d_reg  <= d_next;
        r_reg  <= r_next;
    end

    // mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decrypt_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            decrypt_reg <= cfg_wr_data;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            out_byte_reg <= r_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign sts.ptr_half = (ptr_reg == HALF_POINT);
    assign sts.out_free = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

// ===== sv/ssc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssc_ctrl
// Sequencer for the cipher: walks the key-absorb, keystream, update and
// remix step sequences and hands results to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_ctrl
    import ssc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_cmd,
    output logic            in_ready,
    input  wire ssc_sts_t   sts,
    output ssc_ctl_t        ctl
);

    logic [STEP_W-1:0] state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic              nib_reg, nib_next;
    logic              remix_reg, remix_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              take;
    logic              proc;
    logic              load_out;

    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_ready && in_valid;
    assign proc     = (cmd_reg == CMD_PROCESS);
    assign load_out = (state_reg == ST_EMIT) && sts.out_free;

    // next-state logic
    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        nib_next   = nib_reg;
        remix_next = remix_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    cmd_next   = in_cmd;
                    nib_next   = 1'b0;
                    remix_next = 1'b0;
                    case (in_cmd)
                        CMD_ABSORB:  state_next = ST_JADD;
                        CMD_PROCESS: state_next = ST_KA;
                        CMD_SQUEEZE: state_next = ST_UA;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_JADD: begin
                nib_next   = 1'b0;
                state_next = ST_NCHK;
            end
            ST_NCHK: begin
                if (sts.ptr_half) begin
                    remix_next = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_UA;
                end else begin
                    state_next = ST_NR0;
                end
            end
            ST_NR0: state_next = ST_NR1;
            ST_NR1: state_next = ST_NW0;
            ST_NW0: state_next = ST_NW1;
            ST_NW1: begin
                if (!nib_reg) begin
                    nib_next   = 1'b1;
                    state_next = ST_NCHK;
                end else if (proc) begin
                    state_next = ST_UA;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_UA: state_next = ST_UB;
            ST_UB: state_next = ST_UC;
            ST_UC: state_next = ST_UD;
            ST_UD: state_next = ST_UE;
            ST_UE: begin
                if (remix_reg) begin
                    if (cnt_reg == CNT_LAST) begin
                        state_next = ST_RDONE;
                    end else begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_UA;
                    end
                end else if (proc) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_KA;
                end
            end
            ST_RDONE: begin
                remix_next = 1'b0;
                state_next = ST_NR0;
            end
            ST_KA: state_next = ST_KB;
            ST_KB: state_next = ST_KC;
            ST_KC: state_next = ST_KD;
            ST_KD: state_next = proc ? ST_JADD : ST_EMIT;
            ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cmd_reg   <= CMD_ABSORB;
            nib_reg   <= 1'b0;
            remix_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            nib_reg   <= nib_next;
            remix_reg <= remix_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign ctl.step     = state_reg;
    assign ctl.take     = take;
    assign ctl.nib_hi   = nib_reg;
    assign ctl.proc     = proc;
    assign ctl.load_out = load_out;

endmodule

`default_nettype wire

// ===== sv/sponge_stream_cipher_byte.sv =====
// ----------------------------------------------------------------------------
// sponge_stream_cipher_byte
// Byte-serial sponge stream cipher over a 256-byte permutation table.
// ----------------------------------------------------------------------------
// One byte command at a time, over a permutation memory with one read port,
// one write port and registered read; each step makes at most one table
// access. A key byte runs the key absorb; a squeeze runs the state update
// and keystream walk, a process byte the keystream walk, key absorb and
// state update, each then with the output handoff. Whenever the absorb
// pointer reaches the half point, the next nibble first runs the remix of
// 512 updates. The output register lets a new command start while the last
// result still waits on m_tready; a command producing a result stalls in its
// final cycle only if the previous result has not been taken. Command code 3
// is accepted and dropped. decrypt_mode selects whether process absorbs the
// incoming byte (0) or the produced byte (1); write it only while idle.
`default_nettype none

module sponge_stream_cipher_byte
    import ssc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration: decrypt_mode
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    // command input
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] data_byte
    input  wire logic [1:0] s_tuser,    // [1:0] cmd
    // result output
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata     // [7:0] out_byte
);

    ssc_ctl_t ctl;
    ssc_sts_t sts;

    // sequencer
    ssc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // table and registers
    ssc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .sts         (sts),
        .in_byte     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_byte    (m_tdata)
    );

endmodule

`default_nettype wire

// ===== sv/ssc_checker.sv =====
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks for the sponge stream cipher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_checker
    import ssc_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [1:0] s_tuser,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result survives reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a key byte produces no result
    a_absorb_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_ABSORB) && !m_tvalid |=> !m_tvalid)
        else $error("key byte produced a result");

    // a real command keeps the input closed on the next cycle
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready &&
        (s_tuser == CMD_ABSORB || s_tuser == CMD_PROCESS || s_tuser == CMD_SQUEEZE)
        |=> !s_tready)
        else $error("input open right after a command transfer");

    // the unused code is dropped at once
    a_unused_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_UNUSED) |=> s_tready)
        else $error("unused command stalled the input");

endmodule

bind sponge_stream_cipher_byte ssc_checker u_ssc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
